// ===== sv/rsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
`default_nettype none

package rsc_pkg;

    localparam int DATA_W      = 64;
    localparam int DEPTH_OUT_W = 8;
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_PRINT = 3'd5,
        OP_SWAP  = 3'd6,
        OP_DUP   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNDER   = 2'd1,
        STAT_OVER    = 2'd2,
        STAT_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PUSH,
        S_SWAP_A,
        S_SWAP_B,
        S_MUL_LL,
        S_MUL_LH,
        S_MUL_HL,
        S_DIV,
        S_COMMIT,
        S_DONE
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic rd_en;     // sample stack entry below top
        logic load_in;   // capture input beat
        logic check;     // latch status, set up operands
        logic push;      // write new top (push or dup)
        logic swap_a;    // old top to second slot
        logic swap_b;    // old second to top slot
        logic mul_ll;
        logic mul_lh;
        logic mul_hl;
        logic div_step;
        logic commit;    // write binary-op result, pop one
        logic out_load;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        op_t  op;
        logic err;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/rsc_ctrl.sv =====
// Sequencer for the RPN stack calculator.
`default_nettype none

module rsc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rsc_pkg::dp_stat_t stat,
    output rsc_pkg::cmd_t          cmd
);
    import rsc_pkg::*;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                div_cnt_next = '0;
                if (stat.err) begin
                    state_next = S_DONE;
                end else begin
                    unique case (stat.op)
                        OP_PUSH, OP_DUP: state_next = S_PUSH;
                        OP_ADD, OP_SUB:  state_next = S_COMMIT;
                        OP_MUL:          state_next = S_MUL_LL;
                        OP_DIV:          state_next = S_DIV;
                        OP_PRINT:        state_next = S_DONE;
                        OP_SWAP:         state_next = S_SWAP_A;
                        default:         state_next = S_DONE;
                    endcase
                end
            end
            S_PUSH:   state_next = S_DONE;
            S_SWAP_A: state_next = S_SWAP_B;
            S_SWAP_B: state_next = S_DONE;
            S_MUL_LL: state_next = S_MUL_LH;
            S_MUL_LH: state_next = S_MUL_HL;
            S_MUL_HL: state_next = S_COMMIT;
            S_DIV: begin
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST) state_next = S_COMMIT;
            end
            S_COMMIT: state_next = S_DONE;
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.load_in = s_valid;
            end
            S_CHECK:  cmd.check    = 1'b1;
            S_PUSH:   cmd.push     = 1'b1;
            S_SWAP_A: cmd.swap_a   = 1'b1;
            S_SWAP_B: cmd.swap_b   = 1'b1;
            S_MUL_LL: cmd.mul_ll   = 1'b1;
            S_MUL_LH: cmd.mul_lh   = 1'b1;
            S_MUL_HL: cmd.mul_hl   = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_COMMIT: cmd.commit   = 1'b1;
            S_DONE:   cmd.out_load = stat.out_free;
            default:  cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/rsc_datapath.sv =====
// Stack store, top register, multiply/divide units and result register.
`default_nettype none

module rsc_datapath #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire rsc_pkg::cmd_t                      cmd,
    output rsc_pkg::dp_stat_t                       stat,
    input  wire logic [2:0]                         s_op,
    input  wire logic signed [rsc_pkg::DATA_W-1:0]  s_operand,
    input  wire logic                               m_ready,
    output logic                                    m_valid,
    output logic signed [rsc_pkg::DATA_W-1:0]       m_top_value,
    output logic [rsc_pkg::DEPTH_OUT_W-1:0]         m_depth,
    output logic [1:0]                              m_status,
    output logic                                    m_printed
);
    import rsc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    op_t               op_reg;
    logic [DATA_W-1:0] operand_reg;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] rem_reg, quo_reg, dvs_reg;
    logic              neg_reg;
    status_t           status_reg;
    logic              m_valid_reg;

    // stack pointers
    logic [DW-1:0] d_m1, d_m2;
    assign d_m1 = depth_reg - DW'(1);
    assign d_m2 = depth_reg - DW'(2);

    // error check
    logic    lt2, empty, full;
    status_t chk_code;
    assign lt2   = depth_reg < DW'(2);
    assign empty = depth_reg == '0;
    assign full  = depth_reg == FULL;

    always_comb begin
        unique case (op_reg)
            OP_PUSH:                chk_code = full ? STAT_OVER : STAT_OK;
            OP_ADD, OP_SUB, OP_MUL: chk_code = lt2 ? STAT_UNDER : STAT_OK;
            OP_DIV: begin
                if (lt2)                 chk_code = STAT_UNDER;
                else if (top_reg == '0)  chk_code = STAT_DIVZERO;
                else                     chk_code = STAT_OK;
            end
            OP_PRINT:               chk_code = empty ? STAT_UNDER : STAT_OK;
            OP_SWAP:                chk_code = lt2 ? STAT_UNDER : STAT_OK;
            OP_DUP: begin
                if (empty)     chk_code = STAT_UNDER;
                else if (full) chk_code = STAT_OVER;
                else           chk_code = STAT_OK;
            end
            default:                chk_code = STAT_OK;
        endcase
    end

    assign stat.op       = op_reg;
    assign stat.err      = chk_code != STAT_OK;
    assign stat.out_free = !m_valid_reg || m_ready;

    // shared 32x32 multiplier
    logic [31:0]       mul_x, mul_y;
    logic [DATA_W-1:0] prod;
    always_comb begin
        mul_x = a_reg[31:0];
        mul_y = top_reg[31:0];
        if (cmd.mul_lh) mul_y = top_reg[63:32];
        if (cmd.mul_hl) mul_x = a_reg[63:32];
    end
    assign prod = {32'd0, mul_x} * {32'd0, mul_y};

    // restoring divider step
    logic [DATA_W:0] shifted, diff;
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // result of a binary op
    logic [DATA_W-1:0] res;
    assign res = (op_reg == OP_DIV) ? (neg_reg ? ('0 - quo_reg) : quo_reg) : acc_reg;

    logic [DATA_W-1:0] push_data;
    assign push_data = (op_reg == OP_PUSH) ? operand_reg : top_reg;

    // single write port
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = depth_reg[AW-1:0];
        wr_data    = push_data;
        top_next   = top_reg;
        depth_next = depth_reg;
        priority if (cmd.push) begin
            wr_en      = 1'b1;
            top_next   = push_data;
            depth_next = depth_reg + DW'(1);
        end else if (cmd.swap_a) begin
            wr_en   = 1'b1;
            wr_addr = d_m2[AW-1:0];
            wr_data = top_reg;
        end else if (cmd.swap_b) begin
            wr_en    = 1'b1;
            wr_addr  = d_m1[AW-1:0];
            wr_data  = a_reg;
            top_next = a_reg;
        end else if (cmd.commit) begin
            wr_en      = 1'b1;
            wr_addr    = d_m2[AW-1:0];
            wr_data    = res;
            top_next   = res;
            depth_next = d_m1;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (cmd.rd_en) a_reg <= mem[d_m2[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            if (cmd.out_load)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (cmd.load_in) begin
            op_reg      <= op_t'(s_op);
            operand_reg <= s_operand;
        end
        if (cmd.check) begin
            status_reg <= chk_code;
            acc_reg    <= (op_reg == OP_SUB) ? (a_reg - top_reg) : (a_reg + top_reg);
            rem_reg    <= '0;
            quo_reg    <= a_reg[DATA_W-1] ? ('0 - a_reg) : a_reg;
            dvs_reg    <= top_reg[DATA_W-1] ? ('0 - top_reg) : top_reg;
            neg_reg    <= a_reg[DATA_W-1] ^ top_reg[DATA_W-1];
        end
        if (cmd.mul_ll) begin
            acc_reg <= prod;
        end else if (cmd.mul_lh || cmd.mul_hl) begin
            acc_reg[DATA_W-1:32] <= acc_reg[DATA_W-1:32] + prod[31:0];
        end
        if (cmd.div_step) begin
            if (!diff[DATA_W]) begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            m_top_value <= empty ? '0 : top_reg;
            m_depth     <= DEPTH_OUT_W'(depth_reg);
            m_status    <= status_reg;
            m_printed   <= (op_reg == OP_PRINT) && (status_reg == STAT_OK);
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== sv/rpn_stack_calculator_unit.sv =====
// Top level of the RPN stack calculator: controller plus datapath.
`default_nettype none

// Reverse Polish calculator on signed 64-bit integers with a stack of
// STACK_DEPTH entries (2 to 4096). Each input beat carries an op (push, add,
// subtract, multiply, divide, print, swap, duplicate) and, for push, the
// operand; each one yields exactly one result beat with the new top (zero
// when empty), the depth masked to 8 bits, a status (ok, underflow, overflow,
// divide by zero) and a print flag. Add, subtract and multiply wrap modulo
// 2^64; divide truncates toward zero and the most negative value over minus
// one wraps to itself. On any error the stack is left as it was. One item is
// worked on at a time, and a new input beat is taken while the previous
// result still waits in the output register. After the check, print and any
// error go straight to the result; push and duplicate write the new top; add
// and subtract commit their result; swap writes its two entries one after
// the other (the store has one write port); multiply sums three 32x32
// partial products through one shared multiplier and divide runs a restoring
// divider that makes one quotient bit per cycle, each before the commit. The
// result goes valid in the same cycle that the next input beat can be taken.
// Reset clears the depth and the output valid; the stack store is not
// cleared, and entries are read only after they have been written.
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [2:0]                         s_op,
    input  wire logic signed [rsc_pkg::DATA_W-1:0]  s_operand,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [rsc_pkg::DATA_W-1:0]       m_top_value,
    output logic [rsc_pkg::DEPTH_OUT_W-1:0]         m_depth,
    output logic [1:0]                              m_status,
    output logic                                    m_printed
);
    import rsc_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    // Sequencer: one state per step of the item, counts divider iterations.
    rsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Stack store, top cache, arithmetic units and the result register.
    rsc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_op        (s_op),
        .s_operand   (s_operand),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_top_value (m_top_value),
        .m_depth     (m_depth),
        .m_status    (m_status),
        .m_printed   (m_printed)
    );

    // One item at a time: input closes right after a beat is taken.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");

    // Only one stack write source per cycle.
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.push, cmd.swap_a, cmd.swap_b, cmd.commit}))
        else $error("conflicting stack writes");

    // Overflow is only reported with a full stack.
    a_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_OVER)) |-> (m_depth == DEPTH_OUT_W'(STACK_DEPTH)))
        else $error("overflow reported below full depth");

    // A print is flagged only on success.
    a_print_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_printed) |-> (m_status == STAT_OK))
        else $error("print flag with error status");

endmodule

`default_nettype wire
